// File: rtl/core/cpl_pkg.sv
// ----------------------------------------------------------------------------
// cpl_pkg
// Widths, types and register codes shared by the closest-points pipeline.
// ----------------------------------------------------------------------------
package cpl_pkg;

  localparam int CW     = 32;            // coordinate width
  localparam int FB     = 16;            // fraction bits
  localparam int NL     = 6;             // output lanes: line 0 xyz, line 1 xyz
  localparam int DW     = CW + 1;        // point difference, signed
  localparam int XW     = 2 * DW + 1;    // cross product component, signed
  localparam int XM     = 2 * DW;        // cross product magnitude
  localparam int HD     = DW;            // digit width of split multiplies
  localparam int NM     = 4 * HD;        // dot product magnitude
  localparam int NS     = NM + 3;        // signed sum of three terms
  localparam int NUMW   = NM + CW;       // offset numerator magnitude
  localparam int QB     = CW + 2;        // quotient bits kept before saturation
  localparam int CMPW   = NM + QB;       // divider compare width
  localparam int LIM_SH = 4 * FB - 32;   // limit scale relative to |c|^2
  localparam int LIMW   = 32;
  localparam int PDW    = 32;
  localparam int RIW    = 1;             // register index bits
  localparam int PAW    = RIW + 2;

  localparam logic [LIMW-1:0] LIM_RST = LIMW'(4295);
  localparam logic [RIW-1:0]  REG_PARALLEL_LIMIT = RIW'(0);

  typedef logic signed [CW-1:0]     coord_t;
  typedef logic signed [DW-1:0]     diff_t;
  typedef logic signed [2*DW-1:0]   prod_t;
  typedef logic signed [XW-1:0]     cross_t;
  typedef logic [XM-1:0]            xmag_t;
  typedef logic [2*HD-1:0]          pp_t;
  typedef logic [NM-1:0]            nmag_t;
  typedef logic signed [NM:0]       term_t;
  typedef logic signed [NS-1:0]     dsum_t;
  typedef logic [CW-1:0]            dmag_t;
  typedef logic [HD+CW-1:0]         npp_t;
  typedef logic [NUMW-1:0]          num_t;
  typedef logic [LIMW-1:0]          lim_t;

  localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};

  // word handed from the product pipeline to the quotient unit
  typedef struct packed {
    logic                  vld;
    logic                  par;
    nmag_t                 a;
    logic [NL-1:0]         neg;
    num_t   [NL-1:0]       num;
    coord_t [NL-1:0]       pt;
  } div_in_t;

  typedef struct packed {
    logic                  vld;
    logic                  found;
    coord_t [NL-1:0]       near;
  } res_t;

endpackage

// File: rtl/core/cpl_in_if.sv
// ----------------------------------------------------------------------------
// cpl_in_if
// Input channel: one pair of lines, each given by two points.
// ----------------------------------------------------------------------------
interface cpl_in_if;
  import cpl_pkg::*;

  logic   valid;
  logic   ready;
  coord_t first_start_x;
  coord_t first_start_y;
  coord_t first_start_z;
  coord_t first_end_x;
  coord_t first_end_y;
  coord_t first_end_z;
  coord_t second_start_x;
  coord_t second_start_y;
  coord_t second_start_z;
  coord_t second_end_x;
  coord_t second_end_y;
  coord_t second_end_z;

  modport src (
    output valid, first_start_x, first_start_y, first_start_z,
    output first_end_x, first_end_y, first_end_z,
    output second_start_x, second_start_y, second_start_z,
    output second_end_x, second_end_y, second_end_z,
    input  ready
  );
  modport snk (
    input  valid, first_start_x, first_start_y, first_start_z,
    input  first_end_x, first_end_y, first_end_z,
    input  second_start_x, second_start_y, second_start_z,
    input  second_end_x, second_end_y, second_end_z,
    output ready
  );
endinterface

// File: rtl/core/cpl_out_if.sv
// ----------------------------------------------------------------------------
// cpl_out_if
// Result channel: found flag and the nearest point on each line.
// ----------------------------------------------------------------------------
interface cpl_out_if;
  import cpl_pkg::*;

  logic   valid;
  logic   ready;
  logic   found;
  coord_t near1_x;
  coord_t near1_y;
  coord_t near1_z;
  coord_t near2_x;
  coord_t near2_y;
  coord_t near2_z;

  modport src (
    output valid, found, near1_x, near1_y, near1_z, near2_x, near2_y, near2_z,
    input  ready
  );
  modport snk (
    input  valid, found, near1_x, near1_y, near1_z, near2_x, near2_y, near2_z,
    output ready
  );
endinterface

// File: rtl/core/cpl_div.sv
// ----------------------------------------------------------------------------
// cpl_div
// Pipelined restoring quotient of the six point offsets, one bit per stage,
// then start-point add, saturation or zeroing of parallel words and the output register.
// ----------------------------------------------------------------------------
module cpl_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  cpl_pkg::div_in_t item_i,
  output cpl_pkg::res_t    res_o
);
  import cpl_pkg::*;

  typedef struct packed {
    logic                par;
    nmag_t               a;
    logic [NL-1:0]       neg;
    logic [NL-1:0]       ovf;
    coord_t [NL-1:0]     pt;
  } ctl_t;

  ctl_t            ct_q [QB+1];
  num_t            dr_q [QB+1][NL];
  logic [QB-1:0]   dq_q [QB+1][NL];
  logic [QB:0]     bv_q;
  logic            ovld_q;
  logic            found_q;
  coord_t [NL-1:0] near_q;

  logic signed [QB:0]   qs [NL];
  logic signed [QB+1:0] sm [NL];
  coord_t [NL-1:0]      nx;

  // quotients at or above 2^QB saturate whatever the start point
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ct_q[0].par <= item_i.par;
      ct_q[0].a   <= item_i.a;
      ct_q[0].neg <= item_i.neg;
      ct_q[0].pt  <= item_i.pt;
      for (int k = 0; k < NL; k++) begin
        ct_q[0].ovf[k] <= CMPW'(item_i.num[k]) >= {item_i.a, {QB{1'b0}}};
        dr_q[0][k]     <= item_i.num[k];
        dq_q[0][k]     <= '0;
      end
    end
  end

  for (genvar s = 1; s <= QB; s++) begin : g_st
    logic [CMPW-1:0] dv;
    logic [CMPW-1:0] rx [NL];
    logic            ge [NL];

    assign dv = CMPW'(ct_q[s-1].a) << (QB - s);
    for (genvar k = 0; k < NL; k++) begin : g_ln
      assign rx[k] = CMPW'(dr_q[s-1][k]);
      assign ge[k] = rx[k] >= dv;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ct_q[s] <= ct_q[s-1];
        for (int k = 0; k < NL; k++) begin
          dr_q[s][k] <= ge[k] ? NUMW'(rx[k] - dv) : dr_q[s-1][k];
          dq_q[s][k] <= {dq_q[s-1][k][QB-2:0], ge[k]};
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NL; k++) begin
      qs[k] = ct_q[QB].neg[k] ? -$signed({1'b0, dq_q[QB][k]})
                              :  $signed({1'b0, dq_q[QB][k]});
      sm[k] = (QB+2)'($signed(ct_q[QB].pt[k])) + (QB+2)'(qs[k]);
      if (ct_q[QB].par) begin
        nx[k] = '0;
      end else if (ct_q[QB].ovf[k]) begin
        nx[k] = ct_q[QB].neg[k] ? CMIN : CMAX;
      end else if (sm[k][QB+1:CW-1] == '0 || sm[k][QB+1:CW-1] == '1) begin
        nx[k] = sm[k][CW-1:0];
      end else begin
        nx[k] = sm[k][QB+1] ? CMIN : CMAX;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      found_q <= !ct_q[QB].par;
      near_q  <= nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q   <= '0;
      ovld_q <= 1'b0;
    end else if (en_i) begin
      bv_q   <= {bv_q[QB-1:0], item_i.vld};
      ovld_q <= bv_q[QB];
    end
  end

  assign res_o.vld   = ovld_q;
  assign res_o.found = found_q;
  assign res_o.near  = near_q;

`ifndef SYNTH
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i |=> bv_q[0] == $past(item_i.vld))
    else $error("quotient unit lost or invented a word");

  a_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bv_q[QB] && !ct_q[QB].par && !ct_q[QB].ovf[0]
      |-> CMPW'(dr_q[QB][0]) < CMPW'(ct_q[QB].a))
    else $error("final remainder not below divisor");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovld_q && !found_q |-> near_q == '0)
    else $error("parallel result carries nonzero points");
`endif

endmodule

// File: rtl/core/closest_points_two_lines_top.sv
// ----------------------------------------------------------------------------
// closest_points_two_lines_top
// Nearest points between two 3D lines in signed Q16.16, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one line pair per clock and returns one result word per pair, in
// order. Each pair passes through 11 stages of differences, cross and dot
// products on split multipliers, then a load stage and a 34-stage quotient
// unit that retires one quotient bit per stage, then the output register.
// The pipeline only holds when a result word waits at the output and the
// sink is not ready. Pairs whose squared cross norm, in units of 2^-32, is
// below parallel_limit (or exactly zero) come back with found low and zero
// points.
// ----------------------------------------------------------------------------
module closest_points_two_lines_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  cpl_in_if.snk                    line_i,
  cpl_out_if.src                   res_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [cpl_pkg::PAW-1:0]  paddr,
  input  logic [cpl_pkg::PDW-1:0]  pwdata,
  output logic [cpl_pkg::PDW-1:0]  prdata,
  output logic                     pready
);
  import cpl_pkg::*;

  localparam int NF  = 11;   // front stages
  localparam int DMS = 8;    // direction magnitudes kept from stage 2 to 9

  logic           en;
  logic [NF-1:0]  fv_q;
  lim_t           lim_q;
  logic [RIW-1:0] reg_idx;
  div_in_t        dvi;
  res_t           res;

  coord_t ps [NL];
  coord_t pe [NL];

  coord_t p_q    [NF][NL];
  diff_t  d_s1_q [NL];
  diff_t  w_s1_q [3];
  diff_t  opa    [3][3];
  diff_t  opb    [3][3];
  prod_t  pl     [3][3];
  prod_t  pr     [3][3];
  prod_t  pl_q   [3][3];
  prod_t  pr_q   [3][3];
  dmag_t  dm_q   [DMS][NL];
  logic   dn_q   [DMS][NL];
  cross_t x_q    [3][3];
  xmag_t  xm_q   [3][3];
  logic   xs_q   [3][3];
  pp_t    pp_q   [3][3][4];
  logic   s5_q   [3][3];
  nmag_t  mg_q   [3][3];
  logic   s6_q   [3][3];
  term_t  t_q    [3][3];
  dsum_t  sum_q  [3];
  nmag_t  a_q    [3];
  logic   par_q  [3];
  nmag_t  nm_q   [2];
  logic   ns_q   [2];
  npp_t   ndp_q  [NL][4];
  logic   s10_q  [NL];
  num_t   num_q  [NL];
  logic   s11_q  [NL];

  assign en           = !res.vld || res_o.ready;
  assign line_i.ready = en;

  assign ps[0] = line_i.first_start_x;
  assign ps[1] = line_i.first_start_y;
  assign ps[2] = line_i.first_start_z;
  assign ps[3] = line_i.second_start_x;
  assign ps[4] = line_i.second_start_y;
  assign ps[5] = line_i.second_start_z;
  assign pe[0] = line_i.first_end_x;
  assign pe[1] = line_i.first_end_y;
  assign pe[2] = line_i.first_end_z;
  assign pe[3] = line_i.second_end_x;
  assign pe[4] = line_i.second_end_y;
  assign pe[5] = line_i.second_end_z;

  // stage 1: directions and start offset
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NL; k++) begin
        d_s1_q[k]  <= DW'(pe[k]) - DW'(ps[k]);
        p_q[0][k]  <= ps[k];
      end
      for (int i = 0; i < 3; i++) begin
        w_s1_q[i] <= DW'(ps[3+i]) - DW'(ps[i]);
      end
      for (int s = 1; s < NF; s++) begin
        p_q[s] <= p_q[s-1];
      end
    end
  end

  // cross operand sets: c = d1 x d2, v1 = w x d2, v2 = w x d1
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      opa[0][i] = d_s1_q[i];
      opb[0][i] = d_s1_q[3+i];
      opa[1][i] = w_s1_q[i];
      opb[1][i] = d_s1_q[3+i];
      opa[2][i] = w_s1_q[i];
      opb[2][i] = d_s1_q[i];
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_xg
    for (genvar i = 0; i < 3; i++) begin : g_xi
      localparam int I1 = (i + 1) % 3;
      localparam int I2 = (i + 2) % 3;
      assign pl[g][i] = opa[g][I1] * opb[g][I2];
      assign pr[g][i] = opa[g][I2] * opb[g][I1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // stage 2: cross partial products, direction sign and magnitude
      pl_q <= pl;
      pr_q <= pr;
      for (int k = 0; k < NL; k++) begin
        dm_q[0][k] <= d_s1_q[k][DW-1] ? CW'(-d_s1_q[k]) : CW'(d_s1_q[k]);
        dn_q[0][k] <= d_s1_q[k][DW-1];
      end
      for (int s = 1; s < DMS; s++) begin
        dm_q[s] <= dm_q[s-1];
        dn_q[s] <= dn_q[s-1];
      end
      for (int g = 0; g < 3; g++) begin
        for (int i = 0; i < 3; i++) begin
          // stage 3: cross components
          x_q[g][i]  <= XW'(pl_q[g][i]) - XW'(pr_q[g][i]);
          // stage 4: sign and magnitude
          xs_q[g][i] <= x_q[g][i][XW-1];
          xm_q[g][i] <= x_q[g][i][XW-1] ? XM'(-x_q[g][i]) : XM'(x_q[g][i]);
          // stage 5: digit products against c
          pp_q[g][i][0] <= xm_q[g][i][HD-1:0]  * xm_q[0][i][HD-1:0];
          pp_q[g][i][1] <= xm_q[g][i][HD-1:0]  * xm_q[0][i][HD +: HD];
          pp_q[g][i][2] <= xm_q[g][i][HD +: HD] * xm_q[0][i][HD-1:0];
          pp_q[g][i][3] <= xm_q[g][i][HD +: HD] * xm_q[0][i][HD +: HD];
          s5_q[g][i]    <= xs_q[g][i] ^ xs_q[0][i];
          // stage 6: full magnitude
          mg_q[g][i] <= NM'(pp_q[g][i][0]) + (NM'(pp_q[g][i][1]) << HD)
                      + (NM'(pp_q[g][i][2]) << HD) + (NM'(pp_q[g][i][3]) << (2 * HD));
          s6_q[g][i] <= s5_q[g][i];
          // stage 7: signed term
          t_q[g][i]  <= s6_q[g][i] ? -term_t'({1'b0, mg_q[g][i]})
                                   :  term_t'({1'b0, mg_q[g][i]});
        end
        // stage 8: |c|^2, n1, n2
        sum_q[g] <= NS'(t_q[g][0]) + NS'(t_q[g][1]) + NS'(t_q[g][2]);
      end
      // stage 9: parallel test, numerator magnitudes
      a_q[0]   <= sum_q[0][NM-1:0];
      par_q[0] <= (sum_q[0] == '0) ||
                  (sum_q[0][NM-1:LIM_SH] < (NM-LIM_SH)'(lim_q));
      for (int j = 0; j < 2; j++) begin
        nm_q[j] <= sum_q[j+1][NS-1] ? NM'(-sum_q[j+1]) : NM'(sum_q[j+1]);
        ns_q[j] <= sum_q[j+1][NS-1];
      end
      for (int s = 1; s < 3; s++) begin
        a_q[s]   <= a_q[s-1];
        par_q[s] <= par_q[s-1];
      end
      for (int k = 0; k < NL; k++) begin
        // stage 10: n times |d| in digits
        for (int q = 0; q < 4; q++) begin
          ndp_q[k][q] <= nm_q[(k < 3) ? 0 : 1][q*HD +: HD] * dm_q[DMS-1][k];
        end
        s10_q[k] <= ns_q[(k < 3) ? 0 : 1] ^ dn_q[DMS-1][k];
        // stage 11: numerator
        num_q[k] <= NUMW'(ndp_q[k][0]) + (NUMW'(ndp_q[k][1]) << HD)
                  + (NUMW'(ndp_q[k][2]) << (2 * HD)) + (NUMW'(ndp_q[k][3]) << (3 * HD));
        s11_q[k] <= s10_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
    end else if (en) begin
      fv_q <= {fv_q[NF-2:0], line_i.valid};
    end
  end

  always_comb begin
    dvi.vld = fv_q[NF-1];
    dvi.par = par_q[2];
    dvi.a   = a_q[2];
    for (int k = 0; k < NL; k++) begin
      dvi.neg[k] = s11_q[k];
      dvi.num[k] = num_q[k];
      dvi.pt[k]  = p_q[NF-1][k];
    end
  end

  cpl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .item_i (dvi),
    .res_o  (res)
  );

  assign res_o.valid   = res.vld;
  assign res_o.found   = res.found;
  assign res_o.near1_x = res.near[0];
  assign res_o.near1_y = res.near[1];
  assign res_o.near1_z = res.near[2];
  assign res_o.near2_x = res.near[3];
  assign res_o.near2_y = res.near[4];
  assign res_o.near2_z = res.near[5];

  // register port
  assign reg_idx = paddr[PAW-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= LIM_RST;
    end else if (psel && penable && pwrite && pready && reg_idx == REG_PARALLEL_LIMIT) begin
      lim_q <= pwdata[LIMW-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PARALLEL_LIMIT: prdata = PDW'(lim_q);
      default:            prdata = '0;
    endcase
  end

`ifndef SYNTH
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_i.valid && line_i.ready |=> fv_q[0])
    else $error("accepted word did not enter the pipeline");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(fv_q))
    else $error("pipeline moved during a stall");

  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && reg_idx == REG_PARALLEL_LIMIT
      |=> lim_q == $past(pwdata[LIMW-1:0]))
    else $error("limit register write lost");
`endif

endmodule

// File: tb/sv/tb_closest_points_two_lines_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_closest_points_two_lines_top
// Self-checking bench for the closest-points-between-two-lines pipeline.
// ----------------------------------------------------------------------------
// A driver pushes line pairs from a queue, a monitor takes result words and
// compares them with a wide-integer prediction made when each pair is taken.
// The run walks through several parallel limits and idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_closest_points_two_lines_top;
  import cpl_pkg::*;

  typedef logic signed [287:0] wide_t;
  typedef coord_t [11:0] pair_t;  // fsx fsy fsz fex fey fez ssx ssy ssz sex sey sez

  typedef struct packed {
    logic   found;
    coord_t [5:0] near;
  } near_t;

  localparam int LATENCY = 60;
  localparam int WDOG_LIMIT = 4000;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [PAW-1:0] paddr;
  logic [PDW-1:0] pwdata;
  logic [PDW-1:0] prdata;
  logic pready;

  cpl_in_if  lines();
  cpl_out_if res();

  closest_points_two_lines_top i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .line_i  (lines.snk),
    .res_o   (res.src),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  pair_t pending_pairs[$];
  near_t expected_near[$];
  pair_t cur_pair;
  lim_t  par_limit = LIM_RST;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  bit    hold_send = 0;
  int    fails = 0;
  int    quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void cross3(input wide_t a[3], input wide_t b[3], output wide_t r[3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic coord_t clamp_coord(wide_t v);
    wide_t hi, lo;
    hi = wide_t'(CMAX);
    lo = wide_t'(CMIN);
    if (v > hi) return CMAX;
    if (v < lo) return CMIN;
    return coord_t'(v);
  endfunction

  function automatic near_t nearest_points(pair_t p, lim_t lim);
    wide_t p1[3], p2[3], d1[3], d2[3], w[3], c[3], v1[3], v2[3];
    wide_t a, n1, n2, lim_w;
    near_t r;
    for (int i = 0; i < 3; i++) begin
      p1[i] = wide_t'(p[i]);
      d1[i] = wide_t'(p[3+i]) - p1[i];
      p2[i] = wide_t'(p[6+i]);
      d2[i] = wide_t'(p[9+i]) - p2[i];
      w[i]  = p2[i] - p1[i];
    end
    cross3(d1, d2, c);
    a = c[0] * c[0] + c[1] * c[1] + c[2] * c[2];
    lim_w = wide_t'({1'b0, lim}) <<< LIM_SH;
    r = '0;
    if (a == 0 || a < lim_w) return r;
    cross3(w, d2, v1);
    cross3(w, d1, v2);
    n1 = v1[0] * c[0] + v1[1] * c[1] + v1[2] * c[2];
    n2 = v2[0] * c[0] + v2[1] * c[1] + v2[2] * c[2];
    r.found = 1'b1;
    for (int i = 0; i < 3; i++) begin
      r.near[i]   = clamp_coord(p1[i] + (n1 * d1[i]) / a);
      r.near[3+i] = clamp_coord(p2[i] + (n2 * d2[i]) / a);
    end
    return r;
  endfunction

  function automatic coord_t rnd_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(32'h00ffffff)) - 32'sh0080_0000);
      default: return coord_t'($signed($urandom_range(32'h0007ffff)) - 32'sh0004_0000);
    endcase
  endfunction

  // mostly moderate geometry, some full range, some near-parallel pairs
  function automatic pair_t rnd_pair();
    pair_t p;
    int sel, m;
    sel = $urandom_range(99);
    m = (sel < 20) ? 0 : (sel < 70) ? 1 : 2;
    for (int i = 0; i < 12; i++) p[i] = rnd_coord(m);
    if (sel >= 80) begin
      for (int i = 0; i < 3; i++)
        p[9+i] = p[6+i] + (p[3+i] - p[i]) + coord_t'($signed($urandom_range(64)) - 32);
    end
    return p;
  endfunction

  function automatic pair_t mk_pair(coord_t a0, a1, a2, b0, b1, b2,
                                    coord_t e0, e1, e2, f0, f1, f2);
    return {f2, f1, f0, e2, e1, e0, b2, b1, b0, a2, a1, a0};
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fails++;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lines.valid <= 1'b0;
      {lines.second_end_z, lines.second_end_y, lines.second_end_x,
       lines.second_start_z, lines.second_start_y, lines.second_start_x,
       lines.first_end_z, lines.first_end_y, lines.first_end_x,
       lines.first_start_z, lines.first_start_y, lines.first_start_x} <= '0;
    end else begin
      if (lines.valid && lines.ready)
        expected_near.push_back(nearest_points(cur_pair, par_limit));
      if (!lines.valid || lines.ready) begin
        if (pending_pairs.size() > 0 && !hold_send &&
            $urandom_range(99) >= send_idle_pct) begin
          cur_pair = pending_pairs.pop_front();
          lines.valid <= 1'b1;
          {lines.second_end_z, lines.second_end_y, lines.second_end_x,
           lines.second_start_z, lines.second_start_y, lines.second_start_x,
           lines.first_end_z, lines.first_end_y, lines.first_end_x,
           lines.first_start_z, lines.first_start_y, lines.first_start_x} <= cur_pair;
        end else begin
          lines.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    near_t want;
    if (!rst_ni) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (expected_near.size() == 0) begin
          report("unexpected word", res.near1_x, '0);
        end else begin
          want = expected_near.pop_front();
          if (res.found !== want.found) report("found", res.found, want.found);
          if (res.near1_x !== want.near[0]) report("near1_x", res.near1_x, want.near[0]);
          if (res.near1_y !== want.near[1]) report("near1_y", res.near1_y, want.near[1]);
          if (res.near1_z !== want.near[2]) report("near1_z", res.near1_z, want.near[2]);
          if (res.near2_x !== want.near[3]) report("near2_x", res.near2_x, want.near[3]);
          if (res.near2_y !== want.near[4]) report("near2_y", res.near2_y, want.near[4]);
          if (res.near2_z !== want.near[5]) report("near2_z", res.near2_z, want.near[5]);
        end
      end
      res.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog: only counts while work is outstanding
  always @(posedge clk_i) begin
    if ((lines.valid && lines.ready) || (res.valid && res.ready) ||
        (pending_pairs.size() == 0 && expected_near.size() == 0))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_limit(lim_t v);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= PAW'(REG_PARALLEL_LIMIT) << 2;
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    par_limit = v;
  endtask

  task automatic drain();
    wait (pending_pairs.size() == 0 && !lines.valid);
    wait (expected_near.size() == 0);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic add_directed();
    coord_t one;
    one = 32'sh0001_0000;
    // zero-length lines, cross product exactly zero
    pending_pairs.push_back('0);
    // perpendicular skew lines
    pending_pairs.push_back(mk_pair(0, 0, 0, one, 0, 0, 0, 0, one, 0, one, one));
    // intersecting lines
    pending_pairs.push_back(mk_pair(-one, 0, 0, one, 0, 0, 0, -one, 0, 0, one, 0));
    // exactly parallel
    pending_pairs.push_back(mk_pair(0, 0, 0, one, one, 0, 0, 0, one, one, one, one));
    // almost parallel, cross norm tiny
    pending_pairs.push_back(mk_pair(0, 0, 0, one, 0, 0, 0, one, 0, one, one, 1));
    pending_pairs.push_back(mk_pair(0, 0, 0, one, 0, 0, 0, one, 0, one, one, 32'sh10));
    // extremes of the coordinate range
    pending_pairs.push_back(mk_pair(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX,
                                    CMAX, CMIN, CMAX, CMIN, CMAX, CMIN));
    pending_pairs.push_back(mk_pair(CMAX, CMAX, CMAX, CMIN, CMAX, CMIN,
                                    CMIN, CMIN, CMAX, CMAX, CMIN, CMIN));
    pending_pairs.push_back(mk_pair(CMIN, 0, 0, CMAX, 0, 0, 0, CMIN, CMAX, 0, CMAX, CMIN));
    pending_pairs.push_back({12{CMAX}});
    pending_pairs.push_back({12{CMIN}});
    pending_pairs.push_back({12{32'hffff_ffff}});
    // short perpendicular segments far apart: offsets span the coordinate range
    pending_pairs.push_back(mk_pair(CMIN, 0, 0, CMIN + 1, 0, 0, CMAX, 0, one, CMAX, 1, one));
    pending_pairs.push_back(mk_pair(CMAX, CMAX, 0, CMAX - 1, CMAX, 0,
                                    CMIN, CMIN, one, CMIN, CMIN + 1, one));
    // fractional parts only
    pending_pairs.push_back(mk_pair(1, 2, 3, 32'sh7fff, -5, 9,
                                    -7, 11, -13, 17, -32'sh8000, 19));
  endtask

  task automatic run_phase(int n, int idle, int stall, lim_t lim, bit pause_mid);
    write_limit(lim);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) pending_pairs.push_back(rnd_pair());
    if (pause_mid) begin
      wait (pending_pairs.size() < n / 2);
      hold_send = 1;
      wait (!lines.valid);
      wait (expected_near.size() == 0);
      hold_send = 0;
    end
    drain();
  endtask

  initial begin
    rst_ni  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed pairs under the reset limit and with limit zero
    add_directed();
    drain();
    write_limit('0);
    add_directed();
    drain();

    run_phase(350, 0,  0,  LIM_RST, 1'b0);
    run_phase(300, 58, 0,  32'hffff_ffff, 1'b1);
    run_phase(300, 0,  58, 32'd1, 1'b0);
    run_phase(300, 38, 38, $urandom, 1'b0);
    run_phase(150, 0,  0,  '0, 1'b0);

    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
